// ===== design/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants for the trapezoidal motion profile generator.
// ----------------------------------------------------------------------------
package tmp_pkg;

  // Operations of the iterative arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  // Motion phases as reported on the result channel.
  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // Command to the iterative unit.
  typedef struct packed {
    logic        start;
    unit_op_e    op;
    logic [63:0] a;
    logic [63:0] b;
  } iu_cmd_t;

  // Response from the iterative unit.
  typedef struct packed {
    logic        done;
    logic        rem_nz;
    logic [63:0] result;
  } iu_rsp_t;

  localparam int unsigned MulSteps  = 32;
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned SqrtSteps = 32;

  localparam logic [30:0] T32Max   = 31'h7FFF_FFFF;
  localparam logic [63:0] Big47    = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [31:0] NegLimit = 32'h8000_0000;
  localparam logic [16:0] TickMax  = 17'd65536;

  localparam logic [30:0] VmaxReset = 31'd3276800;
  localparam logic [30:0] AmaxReset = 31'd1310720;
  localparam logic [16:0] TickReset = 17'd66;

  // Configuration register indexes.
  localparam logic [1:0] REG_VMAX = 2'd0;
  localparam logic [1:0] REG_AMAX = 2'd1;
  localparam logic [1:0] REG_TICK = 2'd2;

endpackage

// ===== design/tmp_iter_unit.sv =====
// ----------------------------------------------------------------------------
// tmp_iter_unit
// Iterative arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, all on one shared 64-bit adder.
// ----------------------------------------------------------------------------
module tmp_iter_unit
  import tmp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  iu_cmd_t cmd_i,
  output iu_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  unit_op_e    op_q;
  logic [6:0]  cnt_q;
  logic [63:0] acc_q;
  logic [63:0] opa_q;
  logic [63:0] opb_q;
  logic [63:0] rem_q;

  logic [63:0] add_a;
  logic [63:0] add_b;
  logic        sub;
  logic [64:0] sum;
  logic        geq;

  // Operand selection for the shared adder.
  always_comb begin
    case (op_q)
      OP_DIV: begin
        add_a = {rem_q[62:0], opa_q[63]};
        add_b = opb_q;
        sub   = 1'b1;
      end
      OP_SQRT: begin
        add_a = {rem_q[61:0], opa_q[63:62]};
        add_b = {acc_q[61:0], 2'b01};
        sub   = 1'b1;
      end
      default: begin
        add_a = acc_q;
        add_b = opa_q;
        sub   = 1'b0;
      end
    endcase
    sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {64'd0, sub};
    geq = sum[64];
  end

  // One step per cycle until the count runs out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        acc_q  <= '0;
        rem_q  <= '0;
        opa_q  <= cmd_i.a;
        opb_q  <= cmd_i.b;
        case (cmd_i.op)
          OP_DIV:  cnt_q <= 7'(DivSteps);
          OP_SQRT: cnt_q <= 7'(SqrtSteps);
          default: cnt_q <= 7'(MulSteps);
        endcase
      end else if (busy_q) begin
        case (op_q)
          OP_DIV: begin
            rem_q <= geq ? sum[63:0] : add_a;
            opa_q <= {opa_q[62:0], geq};
          end
          OP_SQRT: begin
            rem_q <= geq ? sum[63:0] : add_a;
            acc_q <= {acc_q[62:0], geq};
            opa_q <= {opa_q[61:0], 2'b00};
          end
          default: begin
            if (opb_q[0]) begin
              acc_q <= sum[63:0];
            end
            opa_q <= {opa_q[62:0], 1'b0};
            opb_q <= {1'b0, opb_q[63:1]};
          end
        endcase
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.rem_nz = (rem_q != 64'd0);
  assign rsp_o.result = (op_q == OP_DIV) ? opa_q : acc_q;

endmodule

// ===== design/trapezoidal_motion_profile.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// Trapezoidal velocity profile generator: one tick per beat, replanning on a
// new target, integrating velocity and position in Q16.16.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+----------------------------
//  in       | input     | in_valid_i / in_stall_o  | target_position_i
//  out      | output    | out_valid_o / out_stall_i| position_o velocity_o
//           |           |                          | motion_phase_o
//  cfg      | input     | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//
//  A tick without a replan runs two 32-step multiplies in the shared
//  iterative unit, plus the phase, output and accept states.
//  A replan adds a 32-step multiply, a 64-step divide and, unless the
//  distance difference exceeds Big47, a second 64-step divide; a
//  triangular profile adds a 32-step multiply and a 32-step square root.
//  One beat is processed at a time. Reset is asynchronous and active low
//  and loads the plan state and the default limits. A stalled result waits
//  in the output register while the next beat is already accepted and computed.
// ----------------------------------------------------------------------------
module trapezoidal_motion_profile
  import tmp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] target_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic [1:0]         motion_phase_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic signed [63:0] ValHi = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] ValLo = -ValHi - 64'sd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WAIT_SQ,
    ST_WAIT_BRAKE,
    ST_SPLIT,
    ST_WAIT_CT,
    ST_WAIT_PK,
    ST_WAIT_SQRT,
    ST_WAIT_STEP,
    ST_PHASE,
    ST_WAIT_POS,
    ST_OUT
  } state_e;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [63:0] v);
    if (v > ValHi) begin
      return ValHi[VW-1:0];
    end else if (v < ValLo) begin
      return ValLo[VW-1:0];
    end
    return v[VW-1:0];
  endfunction

  function automatic logic signed [63:0] sx(input logic signed [VW-1:0] v);
    return 64'(v);
  endfunction

  // Configuration registers.
  logic [30:0] vmax_q;
  logic [30:0] amax_q;
  logic [16:0] tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q <= VmaxReset;
      amax_q <= AmaxReset;
      tick_q <= TickReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_VMAX: vmax_q <= cfg_data_i[30:0];
        REG_AMAX: amax_q <= cfg_data_i[30:0];
        REG_TICK: tick_q <= cfg_data_i[16:0];
        default:  ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [30:0] vmax_e;
  logic [30:0] amax_e;
  logic [16:0] dt_e;

  assign vmax_e = (vmax_q == 31'd0) ? 31'd1 : vmax_q;
  assign amax_e = (amax_q == 31'd0) ? 31'd1 : amax_q;
  assign dt_e   = (tick_q > TickMax) ? TickMax : tick_q;

  // Sequencer and plan state.
  state_e                state_q;
  iu_cmd_t               cmd_q;
  iu_rsp_t               rsp;
  logic signed [VW-1:0]  pos_q;
  logic signed [VW-1:0]  vel_q;
  logic signed [VW-1:0]  prev_q;
  logic signed [VW-1:0]  tgt_q;
  logic signed [VW-1:0]  peak_q;
  logic                  dir_q;
  logic signed [31:0]    ct_q;
  logic [30:0]           elapsed_q;
  phase_e                phase_q;
  logic                  tri_q;
  logic [63:0]           dist_q;
  logic [63:0]           brake_q;
  logic [31:0]           stepv_q;
  logic                  out_valid_q;
  logic signed [31:0]    pos_out_q;
  logic signed [31:0]    vel_out_q;
  logic [1:0]            phase_out_q;

  tmp_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_q),
    .rsp_o  (rsp)
  );

  // Input target clamped to the value range, and replan geometry.
  logic signed [VW-1:0] tgt_in;
  logic signed [63:0]   rem_d;
  logic [63:0]          dist_d;

  assign tgt_in = sat_v(64'(target_position_i));
  assign rem_d  = sx(tgt_in) - sx(pos_q);
  assign dist_d = rem_d[63] ? 64'(-rem_d) : 64'(rem_d);

  // Sign-extended state for the result register.
  logic signed [63:0] pos_ext;
  logic signed [63:0] vel_ext;

  assign pos_ext = sx(pos_q);
  assign vel_ext = sx(vel_q);

  // Phase update for one tick.
  logic signed [63:0]   step_s;
  logic signed [63:0]   sv;
  logic signed [VW-1:0] vel_acc;
  logic signed [VW-1:0] vel_dec;
  logic signed [63:0]   vlim_s;
  logic signed [VW-1:0] vel_lim;
  logic signed [63:0]   acc_ext;
  logic [63:0]          acc_mag;
  logic [31:0]          el_sum;
  logic [30:0]          el_sat;
  logic signed [VW-1:0] vel_nx;
  phase_e               phase_nx;
  logic [30:0]          elapsed_nx;
  logic signed [VW-1:0] pos_base;
  logic signed [63:0]   vnx_ext;
  logic [63:0]          vnx_mag;
  logic                 trap;

  always_comb begin
    trap     = !ct_q[31];
    step_s   = $signed({32'd0, stepv_q});
    sv       = dir_q ? -step_s : step_s;
    vel_acc  = sat_v(sx(vel_q) + sv);
    vel_dec  = sat_v(sx(vel_q) - sv);
    vlim_s   = $signed({33'd0, vmax_e});
    vel_lim  = sat_v(dir_q ? -vlim_s : vlim_s);
    acc_ext  = sx(vel_acc);
    acc_mag  = acc_ext[63] ? 64'(-acc_ext) : 64'(acc_ext);
    el_sum   = {1'b0, elapsed_q} + {15'd0, dt_e};
    el_sat   = el_sum[31] ? T32Max : el_sum[30:0];

    vel_nx     = vel_q;
    phase_nx   = phase_q;
    elapsed_nx = elapsed_q;
    pos_base   = pos_q;
    case (phase_q)
      PH_ACCEL: begin
        vel_nx = vel_acc;
        if (trap) begin
          if (acc_mag >= {33'd0, vmax_e}) begin
            phase_nx = PH_CRUISE;
            vel_nx   = vel_lim;
          end
        end else if (dir_q ? (vel_acc <= peak_q) : (vel_acc >= peak_q)) begin
          phase_nx = PH_DECEL;
          vel_nx   = peak_q;
        end
      end
      PH_CRUISE: begin
        if (trap) begin
          elapsed_nx = el_sat;
          if ($signed({1'b0, el_sat}) >= ct_q) begin
            phase_nx = PH_DECEL;
          end
        end
      end
      PH_DECEL: begin
        vel_nx = vel_dec;
        if (dir_q ? (vel_dec >= 0) : (vel_dec <= 0)) begin
          phase_nx = PH_DONE;
          vel_nx   = '0;
        end
      end
      default: begin
        pos_base = tgt_q;
      end
    endcase
    vnx_ext = sx(vel_nx);
    vnx_mag = vnx_ext[63] ? 64'(-vnx_ext) : 64'(vnx_ext);
  end

  // Results computed from the unit's output.
  logic [63:0]        diff;
  logic [63:0]        mag;
  logic [63:0]        q_up;
  logic [31:0]        q32;
  logic signed [63:0] root_s;
  logic signed [63:0] delta;

  always_comb begin
    diff   = dist_q - brake_q;
    mag    = brake_q - dist_q;
    q_up   = rsp.result + {63'd0, rsp.rem_nz};
    q32    = (q_up > {32'd0, NegLimit}) ? NegLimit : q_up[31:0];
    root_s = $signed(rsp.result);
    if (vel_q[VW-1]) begin
      delta = -$signed((rsp.result + 64'd65535) >> 16);
    end else begin
      delta = $signed(rsp.result >> 16);
    end
  end

  // Sequencer: replans on a new target, then steps one tick through the shared unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      pos_q       <= '0;
      vel_q       <= '0;
      prev_q      <= '0;
      peak_q      <= '0;
      dir_q       <= 1'b0;
      ct_q        <= '0;
      elapsed_q   <= '0;
      phase_q     <= PH_ACCEL;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q.start <= 1'b0;
      // The output register loads a new beat or empties when its beat leaves.
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            tgt_q <= tgt_in;
            if (tgt_in != prev_q) begin
              dist_q  <= dist_d;
              dir_q   <= !(tgt_in > pos_q);
              vel_q   <= '0;
              prev_q  <= tgt_in;
              phase_q <= PH_ACCEL;
              cmd_q   <= '{start: 1'b1, op: OP_MUL, a: {33'd0, vmax_e}, b: {33'd0, vmax_e}};
              state_q <= ST_WAIT_SQ;
            end else begin
              cmd_q   <= '{start: 1'b1, op: OP_MUL, a: {33'd0, amax_e}, b: {47'd0, dt_e}};
              state_q <= ST_WAIT_STEP;
            end
          end
        end
        ST_WAIT_SQ: begin
          if (rsp.done) begin
            cmd_q   <= '{start: 1'b1, op: OP_DIV, a: rsp.result, b: {33'd0, amax_e}};
            state_q <= ST_WAIT_BRAKE;
          end
        end
        ST_WAIT_BRAKE: begin
          if (rsp.done) begin
            brake_q <= rsp.result;
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (dist_q >= brake_q) begin
            tri_q <= 1'b0;
            if (diff > Big47) begin
              ct_q      <= $signed({1'b0, T32Max});
              elapsed_q <= '0;
              cmd_q   <= '{start: 1'b1, op: OP_MUL, a: {33'd0, amax_e}, b: {47'd0, dt_e}};
              state_q <= ST_WAIT_STEP;
            end else begin
              cmd_q   <= '{start: 1'b1, op: OP_DIV, a: {diff[47:0], 16'd0}, b: {33'd0, vmax_e}};
              state_q <= ST_WAIT_CT;
            end
          end else begin
            tri_q <= 1'b1;
            if (mag > Big47) begin
              ct_q    <= $signed(NegLimit);
              cmd_q   <= '{start: 1'b1, op: OP_MUL, a: dist_q, b: {33'd0, amax_e}};
              state_q <= ST_WAIT_PK;
            end else begin
              cmd_q   <= '{start: 1'b1, op: OP_DIV, a: {mag[47:0], 16'd0}, b: {33'd0, vmax_e}};
              state_q <= ST_WAIT_CT;
            end
          end
        end
        ST_WAIT_CT: begin
          if (rsp.done) begin
            if (!tri_q) begin
              ct_q      <= (rsp.result > {33'd0, T32Max}) ? $signed({1'b0, T32Max})
                                                          : $signed({1'b0, rsp.result[30:0]});
              elapsed_q <= '0;
              cmd_q   <= '{start: 1'b1, op: OP_MUL, a: {33'd0, amax_e}, b: {47'd0, dt_e}};
              state_q <= ST_WAIT_STEP;
            end else begin
              ct_q    <= -$signed(q32);
              cmd_q   <= '{start: 1'b1, op: OP_MUL, a: dist_q, b: {33'd0, amax_e}};
              state_q <= ST_WAIT_PK;
            end
          end
        end
        ST_WAIT_PK: begin
          if (rsp.done) begin
            cmd_q   <= '{start: 1'b1, op: OP_SQRT, a: rsp.result, b: 64'd0};
            state_q <= ST_WAIT_SQRT;
          end
        end
        ST_WAIT_SQRT: begin
          if (rsp.done) begin
            peak_q  <= sat_v(dir_q ? -root_s : root_s);
            cmd_q   <= '{start: 1'b1, op: OP_MUL, a: {33'd0, amax_e}, b: {47'd0, dt_e}};
            state_q <= ST_WAIT_STEP;
          end
        end
        ST_WAIT_STEP: begin
          if (rsp.done) begin
            stepv_q <= rsp.result[47:16];
            state_q <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          vel_q     <= vel_nx;
          phase_q   <= phase_nx;
          elapsed_q <= elapsed_nx;
          pos_q     <= pos_base;
          cmd_q     <= '{start: 1'b1, op: OP_MUL, a: vnx_mag, b: {47'd0, dt_e}};
          state_q   <= ST_WAIT_POS;
        end
        ST_WAIT_POS: begin
          if (rsp.done) begin
            pos_q   <= sat_v(sx(pos_q) + delta);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            pos_out_q   <= pos_ext[31:0];
            vel_out_q   <= vel_ext[31:0];
            phase_out_q <= phase_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_out_q;
  assign velocity_o     = vel_out_q;
  assign motion_phase_o = phase_out_q;

  // The unit only finishes while the sequencer waits on it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q != ST_IDLE && state_q != ST_OUT && state_q != ST_PHASE))
    else $error("unit finished outside a wait state");

  // An accepted beat keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // A finished profile holds zero velocity.
  a_done_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (vel_q == '0))
    else $error("velocity nonzero in finished phase");

  // Cruise only happens on a trapezoidal plan.
  a_cruise_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CRUISE) |-> !ct_q[31])
    else $error("cruise phase on a triangular plan");

endmodule
